### rtl/blr_pkg.sv
// Package for the line rasterizer: command codes, register indexes and the
// control word passed from the segment setup pipeline to the pixel walker.
// No dependencies.
package blr_pkg;

   // Command field of an input word
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   // Register file: two 32-bit registers at byte addresses 0 and 4
   localparam int  CSR_ADDR_BITS = 3;
   localparam int  CSR_DATA_BITS = 32;
   localparam logic REG_MIN_COORD = 1'b0;
   localparam logic REG_MAX_COORD = 1'b1;

   // Control word leaving the setup pipeline
   typedef struct packed {
      logic valid;
      logic load;
      logic steep;
      logic mirror;
   } seg_ctl_type;

endpackage

### rtl/blr_req_if.sv
// Input channel of the line rasterizer: valid/ready handshake plus one
// command word. Depends on nothing.
interface blr_req_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic signed [COORD_BITS-1:0] x_start;
   logic signed [COORD_BITS-1:0] y_start;
   logic signed [COORD_BITS-1:0] x_end;
   logic signed [COORD_BITS-1:0] y_end;
   logic        [23:0]           color;

   modport source (output valid, command, x_start, y_start, x_end, y_end, color,
                   input ready);
   modport sink   (input valid, command, x_start, y_start, x_end, y_end, color,
                   output ready);
endinterface

### rtl/blr_rsp_if.sv
// Result channel of the line rasterizer: valid/ready handshake plus one
// pixel word. Depends on nothing.
interface blr_rsp_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pixel_x;
   logic signed [COORD_BITS-1:0] pixel_y;
   logic        [23:0]           pixel_color;
   logic                         last_pixel;

   modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel,
                   output ready);
endinterface

### rtl/blr_csr.sv
// Window registers of the line rasterizer behind an APB-style port.
// Depends on blr_pkg.
module blr_csr
   import blr_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [CSR_ADDR_BITS-1:0]     paddr,
   input  logic [CSR_DATA_BITS-1:0]     pwdata,
   output logic [CSR_DATA_BITS-1:0]     prdata,
   output logic                         pready,
   output logic signed [COORD_BITS-1:0] min_coord,
   output logic signed [COORD_BITS-1:0] max_coord
);

   localparam int MAX_RESET = (COORD_BITS > 12) ? 4095 : (2 ** (COORD_BITS - 1)) - 1;

   logic signed [COORD_BITS-1:0] min_ff, min_in;
   logic signed [COORD_BITS-1:0] max_ff, max_in;
   logic                         wr_en;
   logic                         reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_idx = paddr[2];

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_MIN_COORD: min_in = pwdata[COORD_BITS-1:0];
            REG_MAX_COORD: max_in = pwdata[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
         max_ff <= COORD_BITS'(MAX_RESET);
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MIN_COORD: prdata = CSR_DATA_BITS'(min_ff);
         REG_MAX_COORD: prdata = CSR_DATA_BITS'(max_ff);
         default:       prdata = '0;
      endcase
   end

   assign min_coord = min_ff;
   assign max_coord = max_ff;

   a_min_write: assert property (@(posedge clock) disable iff (reset)
      wr_en && reg_idx == REG_MIN_COORD |=> min_ff == $past(pwdata[COORD_BITS-1:0]))
      else $error("min_coord write lost");
   a_max_write: assert property (@(posedge clock) disable iff (reset)
      wr_en && reg_idx == REG_MAX_COORD |=> max_ff == $past(pwdata[COORD_BITS-1:0]))
      else $error("max_coord write lost");
   a_no_write_hold: assert property (@(posedge clock) disable iff (reset)
      !wr_en |=> $stable(min_ff) && $stable(max_ff))
      else $error("window changed without a write");

endmodule

### rtl/blr_setup.sv
// Three-stage segment setup: clamp endpoints, measure spans and pick the
// major axis, then order, mirror and form the error terms. Depends on blr_pkg.
module blr_setup
   import blr_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic signed [COORD_BITS-1:0]   min_coord,
   input  logic signed [COORD_BITS-1:0]   max_coord,
   input  logic                           in_valid,
   input  logic                           in_command,
   input  logic signed [COORD_BITS-1:0]   in_x0,
   input  logic signed [COORD_BITS-1:0]   in_y0,
   input  logic signed [COORD_BITS-1:0]   in_x1,
   input  logic signed [COORD_BITS-1:0]   in_y1,
   input  logic [23:0]                    in_color,
   output seg_ctl_type                    seg_ctl,
   output logic signed [COORD_BITS-1:0]   seg_major,
   output logic signed [COORD_BITS-1:0]   seg_major_end,
   output logic signed [COORD_BITS:0]     seg_minor,
   output logic signed [COORD_BITS+2:0]   seg_err,
   output logic signed [COORD_BITS+2:0]   seg_err_dec,
   output logic signed [COORD_BITS+2:0]   seg_err_inc,
   output logic [23:0]                    seg_color
);

   localparam int N = COORD_BITS;
   localparam int E = COORD_BITS + 3;

   function automatic logic signed [N-1:0] clamp(input logic signed [N-1:0] v,
                                                  input logic signed [N-1:0] lo,
                                                  input logic signed [N-1:0] hi);
      logic signed [N-1:0] r;
      r = (v < lo) ? lo : v;
      r = (r > hi) ? hi : r;
      return r;
   endfunction

   function automatic logic [N-1:0] span(input logic signed [N-1:0] p,
                                         input logic signed [N-1:0] q);
      logic signed [N:0] d;
      d = (q > p) ? ((N+1)'(q) - (N+1)'(p)) : ((N+1)'(p) - (N+1)'(q));
      return d[N-1:0];
   endfunction

   // stage 1: clamped endpoints
   logic                s1_valid_ff, s1_load_ff;
   logic signed [N-1:0] s1_x0_ff, s1_y0_ff, s1_x1_ff, s1_y1_ff;
   logic [23:0]         s1_color_ff;

   // stage 2: spans and axis choice
   logic                s2_valid_ff, s2_load_ff, s2_steep_ff;
   logic signed [N-1:0] s2_x0_ff, s2_y0_ff, s2_x1_ff, s2_y1_ff;
   logic [N-1:0]        s2_adx_ff, s2_ady_ff;
   logic [23:0]         s2_color_ff;
   logic [N-1:0]        adx_in, ady_in;

   // stage 3: segment ready for the walker
   seg_ctl_type         s3_ctl_ff, s3_ctl_in;
   logic signed [N-1:0] s3_major_ff, s3_major_in;
   logic signed [N-1:0] s3_end_ff, s3_end_in;
   logic signed [N:0]   s3_minor_ff, s3_minor_in;
   logic signed [E-1:0] s3_err_ff, s3_err_in;
   logic signed [E-1:0] s3_dec_ff, s3_dec_in;
   logic signed [E-1:0] s3_inc_ff, s3_inc_in;
   logic [23:0]         s3_color_ff;

   logic signed [N-1:0] a0, a1, b0, b1, b_start, b_end;
   logic [N-1:0]        d_major, d_minor;
   logic                swap;
   logic signed [E-1:0] dmaj1, dmaj2, dmin2;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
      if (advance) begin
         s1_load_ff  <= (in_command == CMD_LOAD);
         s1_x0_ff    <= clamp(in_x0, min_coord, max_coord);
         s1_y0_ff    <= clamp(in_y0, min_coord, max_coord);
         s1_x1_ff    <= clamp(in_x1, min_coord, max_coord);
         s1_y1_ff    <= clamp(in_y1, min_coord, max_coord);
         s1_color_ff <= in_color;
      end
   end

   assign adx_in = span(s1_x0_ff, s1_x1_ff);
   assign ady_in = span(s1_y0_ff, s1_y1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_load_ff  <= s1_load_ff;
         s2_x0_ff    <= s1_x0_ff;
         s2_y0_ff    <= s1_y0_ff;
         s2_x1_ff    <= s1_x1_ff;
         s2_y1_ff    <= s1_y1_ff;
         s2_adx_ff   <= adx_in;
         s2_ady_ff   <= ady_in;
         s2_steep_ff <= !(adx_in > ady_in);
         s2_color_ff <= s1_color_ff;
      end
   end

   always_comb begin
      a0      = s2_steep_ff ? s2_y0_ff : s2_x0_ff;
      a1      = s2_steep_ff ? s2_y1_ff : s2_x1_ff;
      b0      = s2_steep_ff ? s2_x0_ff : s2_y0_ff;
      b1      = s2_steep_ff ? s2_x1_ff : s2_y1_ff;
      d_major = s2_steep_ff ? s2_ady_ff : s2_adx_ff;
      d_minor = s2_steep_ff ? s2_adx_ff : s2_ady_ff;
      // order so the major axis increases
      swap    = a0 > a1;
      b_start = swap ? b1 : b0;
      b_end   = swap ? b0 : b1;

      s3_ctl_in.valid  = s2_valid_ff;
      s3_ctl_in.load   = s2_load_ff;
      s3_ctl_in.steep  = s2_steep_ff;
      s3_ctl_in.mirror = b_start > b_end;

      s3_major_in = swap ? a1 : a0;
      s3_end_in   = swap ? a0 : a1;
      s3_minor_in = s3_ctl_in.mirror ? -((N+1)'(b_start)) : (N+1)'(b_start);

      dmaj1 = $signed({3'b000, d_major});
      dmaj2 = $signed({2'b00, d_major, 1'b0});
      dmin2 = $signed({2'b00, d_minor, 1'b0});
      s3_err_in = dmin2 - dmaj1;
      s3_dec_in = dmin2 - dmaj2;
      s3_inc_in = dmin2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         s3_ctl_ff.valid <= s3_ctl_in.valid;
      end
      if (advance) begin
         s3_ctl_ff.load   <= s3_ctl_in.load;
         s3_ctl_ff.steep  <= s3_ctl_in.steep;
         s3_ctl_ff.mirror <= s3_ctl_in.mirror;
         s3_major_ff      <= s3_major_in;
         s3_end_ff        <= s3_end_in;
         s3_minor_ff      <= s3_minor_in;
         s3_err_ff        <= s3_err_in;
         s3_dec_ff        <= s3_dec_in;
         s3_inc_ff        <= s3_inc_in;
         s3_color_ff      <= s2_color_ff;
      end
   end

   assign seg_ctl       = s3_ctl_ff;
   assign seg_major     = s3_major_ff;
   assign seg_major_end = s3_end_ff;
   assign seg_minor     = s3_minor_ff;
   assign seg_err       = s3_err_ff;
   assign seg_err_dec   = s3_dec_ff;
   assign seg_err_inc   = s3_inc_ff;
   assign seg_color     = s3_color_ff;

   a_order: assert property (@(posedge clock) disable iff (reset)
      s3_ctl_ff.valid && s3_ctl_ff.load |-> s3_major_ff <= s3_end_ff)
      else $error("segment not ordered along the major axis");
   a_dec_nonpos: assert property (@(posedge clock) disable iff (reset)
      s3_ctl_ff.valid && s3_ctl_ff.load |-> s3_dec_ff <= 0)
      else $error("minor span exceeds major span");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(s3_ctl_ff.valid) && $stable(s2_valid_ff) && $stable(s1_valid_ff))
      else $error("setup pipeline moved while stalled");

endmodule

### rtl/blr_walker.sv
// Pixel walker: holds the running segment; past the first step it advances
// the error term once per step, registers each pixel. Depends on blr_pkg.
module blr_walker
   import blr_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  seg_ctl_type                   seg_ctl,
   input  logic signed [COORD_BITS-1:0]  seg_major,
   input  logic signed [COORD_BITS-1:0]  seg_major_end,
   input  logic signed [COORD_BITS:0]    seg_minor,
   input  logic signed [COORD_BITS+2:0]  seg_err,
   input  logic signed [COORD_BITS+2:0]  seg_err_dec,
   input  logic signed [COORD_BITS+2:0]  seg_err_inc,
   input  logic [23:0]                   seg_color,
   input  logic                          out_ready,
   output logic                          advance,
   output logic                          out_valid,
   output logic signed [COORD_BITS-1:0]  out_x,
   output logic signed [COORD_BITS-1:0]  out_y,
   output logic [23:0]                   out_color,
   output logic                          out_last
);

   localparam int N = COORD_BITS;
   localparam int E = COORD_BITS + 3;

   logic                running_ff, running_in;
   logic                first_ff, first_in;
   logic                steep_ff, mirror_ff;
   logic signed [N-1:0] major_ff, major_in;
   logic signed [N-1:0] end_ff;
   logic signed [N:0]   minor_ff, minor_in;
   logic signed [E-1:0] err_ff, err_in;
   logic signed [E-1:0] dec_ff, inc_ff;
   logic [23:0]         color_ff;

   logic                out_valid_ff, out_valid_in;
   logic signed [N-1:0] out_x_ff, out_y_ff;
   logic [23:0]         out_color_ff;
   logic                out_last_ff;

   logic                do_load, do_step, last;
   logic signed [N:0]   minor_out;

   assign advance = !out_valid_ff || out_ready;
   assign do_load = advance && seg_ctl.valid && seg_ctl.load;
   assign do_step = advance && seg_ctl.valid && !seg_ctl.load && running_ff;

   always_comb begin
      if (first_ff) begin
         major_in = major_ff;
         minor_in = minor_ff;
         err_in   = err_ff;
      end else begin
         major_in = major_ff + N'(1);
         minor_in = (err_ff >= 0) ? minor_ff + (N+1)'(1) : minor_ff;
         err_in   = err_ff + ((err_ff >= 0) ? dec_ff : inc_ff);
      end
      last       = major_in >= end_ff;
      minor_out  = mirror_ff ? -minor_in : minor_in;

      running_in = running_ff;
      first_in   = first_ff;
      if (do_load) begin
         running_in = 1'b1;
         first_in   = 1'b1;
      end else if (do_step) begin
         running_in = !last;
         first_in   = 1'b0;
      end
      out_valid_in = advance ? do_step : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         first_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         running_ff   <= running_in;
         first_ff     <= first_in;
         out_valid_ff <= out_valid_in;
      end
      if (do_load) begin
         steep_ff  <= seg_ctl.steep;
         mirror_ff <= seg_ctl.mirror;
         major_ff  <= seg_major;
         end_ff    <= seg_major_end;
         minor_ff  <= seg_minor;
         err_ff    <= seg_err;
         dec_ff    <= seg_err_dec;
         inc_ff    <= seg_err_inc;
         color_ff  <= seg_color;
      end else if (do_step) begin
         major_ff <= major_in;
         minor_ff <= minor_in;
         err_ff   <= err_in;
      end
      if (do_step) begin
         out_x_ff     <= steep_ff ? minor_out[N-1:0] : major_in;
         out_y_ff     <= steep_ff ? major_in : minor_out[N-1:0];
         out_color_ff <= color_ff;
         out_last_ff  <= last;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign out_color = out_color_ff;
   assign out_last  = out_last_ff;

   a_first_running: assert property (@(posedge clock) disable iff (reset)
      first_ff |-> running_ff)
      else $error("start pixel pending without a segment");
   a_before_end: assert property (@(posedge clock) disable iff (reset)
      running_ff && !first_ff |-> major_ff < end_ff)
      else $error("walker passed the segment end");
   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_last_ff |-> !running_ff)
      else $error("segment still running after its last pixel");
   a_step_emits: assert property (@(posedge clock) disable iff (reset)
      do_step |=> out_valid_ff)
      else $error("step on a running segment produced no pixel");

endmodule

### rtl/bresenham_line_rasterizer.sv
// Top level of the line rasterizer: window registers, segment setup pipeline
// and pixel walker. Depends on blr_pkg, blr_req_if, blr_rsp_if, blr_csr,
// blr_setup and blr_walker.
//
// Usage
//   req_chan carries command words. A load word (command 0) latches two
//   endpoints and a color, clamps them to [min_coord, max_coord] and
//   replaces any segment in progress; it gives no pixel. Each step word
//   (command 1) gives one pixel word on rsp_chan while a segment runs, with
//   last_pixel set on the final one; steps with no segment give nothing.
//   Throughput: one word per clock on both channels while rsp_chan does not
//   stall. A step's pixel reaches rsp_chan through the three setup stages
//   and then the output register, and a step may follow its load in the
//   very next cycle.
//   Stall: when rsp_chan is not ready with a pixel waiting, every stage
//   holds and req_chan.ready drops in the same cycle; no word is lost.
//   Reset (synchronous, active high): pipeline empty, no segment running,
//   window set to [0, 4095]. Write the window registers (APB, address 0 for
//   min_coord, 4 for max_coord) only while the pipeline is empty.
module bresenham_line_rasterizer
   import blr_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   blr_req_if.sink                  req_chan,
   blr_rsp_if.source                rsp_chan,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   logic signed [COORD_BITS-1:0] min_coord, max_coord;
   logic                         advance;

   seg_ctl_type                  seg_ctl;
   logic signed [COORD_BITS-1:0] seg_major, seg_major_end;
   logic signed [COORD_BITS:0]   seg_minor;
   logic signed [COORD_BITS+2:0] seg_err, seg_err_dec, seg_err_inc;
   logic [23:0]                  seg_color;

   blr_csr #(.COORD_BITS(COORD_BITS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .min_coord (min_coord),
      .max_coord (max_coord)
   );

   // Whole pipeline moves together; the output register is the only
   // place a stall is absorbed.
   assign req_chan.ready = advance;

   blr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .min_coord     (min_coord),
      .max_coord     (max_coord),
      .in_valid      (req_chan.valid),
      .in_command    (req_chan.command),
      .in_x0         (req_chan.x_start),
      .in_y0         (req_chan.y_start),
      .in_x1         (req_chan.x_end),
      .in_y1         (req_chan.y_end),
      .in_color      (req_chan.color),
      .seg_ctl       (seg_ctl),
      .seg_major     (seg_major),
      .seg_major_end (seg_major_end),
      .seg_minor     (seg_minor),
      .seg_err       (seg_err),
      .seg_err_dec   (seg_err_dec),
      .seg_err_inc   (seg_err_inc),
      .seg_color     (seg_color)
   );

   blr_walker #(.COORD_BITS(COORD_BITS)) u_walker (
      .clock         (clock),
      .reset         (reset),
      .seg_ctl       (seg_ctl),
      .seg_major     (seg_major),
      .seg_major_end (seg_major_end),
      .seg_minor     (seg_minor),
      .seg_err       (seg_err),
      .seg_err_dec   (seg_err_dec),
      .seg_err_inc   (seg_err_inc),
      .seg_color     (seg_color),
      .out_ready     (rsp_chan.ready),
      .advance       (advance),
      .out_valid     (rsp_chan.valid),
      .out_x         (rsp_chan.pixel_x),
      .out_y         (rsp_chan.pixel_y),
      .out_color     (rsp_chan.pixel_color),
      .out_last      (rsp_chan.last_pixel)
   );

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("input taken while a pixel is stalled");
   a_no_pixel_idle: assert property (@(posedge clock) disable iff (reset)
      !seg_ctl.valid && advance |=> !rsp_chan.valid)
      else $error("pixel produced without a step word");
   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("register port not ready");

endmodule
